/* rtl/core/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB package
// Item types, pipeline stage bundle and fixed-point constants.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   typedef struct packed {
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_payload_type;

   // scaled terms before the divide by 255
   typedef struct packed {
      logic        valid;
      logic [2:0]  sector;
      logic [7:0]  bri;
      logic [15:0] p_num;
      logic [15:0] q_num;
      logic [15:0] t_num;
   } term_stage_type;

   localparam logic [7:0]  FULL_SCALE = 8'd255;
   localparam logic [16:0] FRAC_ONE   = 17'h10000;
   localparam logic [23:0] DEN_FULL   = 24'hFF0000;

   localparam logic [2:0] SECTOR_RED     = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN   = 3'd2;
   localparam logic [2:0] SECTOR_CYAN    = 3'd3;
   localparam logic [2:0] SECTOR_BLUE    = 3'd4;

endpackage

/* rtl/core/hsv_to_rgb_converter.sv */
// Throughput: one item per cycle; busy is always low.
// Six register stages: hue split, fraction products, complements, value products,
// divide by 255, select.
// Reset clears the stage valid bits only; items in flight are dropped.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB888 converter
// Six-sector HSV to 8-bit RGB in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  hsv2rgb_pkg::req_payload_type req_data,
   output logic                         rsp_valid,
   output hsv2rgb_pkg::rsp_payload_type rsp_data
);

   logic                        req_accept;
   hsv2rgb_pkg::term_stage_type term;

   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   hsv2rgb_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .in_data  (req_data),
      .out_term (term)
   );

   hsv2rgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_term   (term),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_valid_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, 6))
      else $error("result without an accepted item");

   a_gray_on_zero_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.saturation, 6) == 8'd0) |->
      (rsp_data.red == $past(req_data.brightness, 6) &&
       rsp_data.green == $past(req_data.brightness, 6) &&
       rsp_data.blue == $past(req_data.brightness, 6)))
      else $error("zero saturation item not gray");

   a_value_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red == $past(req_data.brightness, 6) ||
                     rsp_data.green == $past(req_data.brightness, 6) ||
                     rsp_data.blue == $past(req_data.brightness, 6)))
      else $error("no channel carries the value");
`endif

endmodule

/* rtl/core/hsv2rgb_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB term scaling
// Four register stages: sector split, fraction products, complements,
// brightness products. Emits p, q and t numerators over 255.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  hsv2rgb_pkg::req_payload_type in_data,
   output hsv2rgb_pkg::term_stage_type  out_term
);

   logic [18:0] hue_x6;

   // stage A
   logic        a_valid_ff, a_valid_in;
   logic [2:0]  a_sector_ff, a_sector_in;
   logic [15:0] a_frac_ff, a_frac_in;
   logic [7:0]  a_sat_ff, a_sat_in;
   logic [7:0]  a_bri_ff, a_bri_in;
   logic [15:0] a_pnum_ff, a_pnum_in;

   // stage B
   logic        b_valid_ff, b_valid_in;
   logic [2:0]  b_sector_ff;
   logic [7:0]  b_bri_ff;
   logic [15:0] b_pnum_ff;
   logic [23:0] b_fs_ff, b_fs_in;
   logic [23:0] b_fns_ff, b_fns_in;
   logic [16:0] frac_inv;
   logic [24:0] fns_full;

   // stage C
   logic        c_valid_ff, c_valid_in;
   logic [2:0]  c_sector_ff;
   logic [7:0]  c_bri_ff;
   logic [15:0] c_pnum_ff;
   logic [23:0] c_dq_ff, c_dq_in;
   logic [23:0] c_dt_ff, c_dt_in;

   // stage D
   logic        d_valid_ff, d_valid_in;
   logic [2:0]  d_sector_ff;
   logic [7:0]  d_bri_ff;
   logic [15:0] d_pnum_ff;
   logic [15:0] d_qnum_ff, d_qnum_in;
   logic [15:0] d_tnum_ff, d_tnum_in;
   logic [31:0] q_prod, t_prod;

   always_comb begin
      hue_x6      = {1'b0, in_data.hue, 2'b00} + {2'b00, in_data.hue, 1'b0};
      a_valid_in  = in_valid;
      a_sector_in = hue_x6[18:16];
      a_frac_in   = hue_x6[15:0];
      a_sat_in    = in_data.saturation;
      a_bri_in    = in_data.brightness;
      a_pnum_in   = 16'(in_data.brightness) *
                    16'(hsv2rgb_pkg::FULL_SCALE - in_data.saturation);

      b_valid_in  = a_valid_ff;
      b_fs_in     = 24'(a_frac_ff) * 24'(a_sat_ff);
      frac_inv    = hsv2rgb_pkg::FRAC_ONE - {1'b0, a_frac_ff};
      fns_full    = 25'(frac_inv) * 25'(a_sat_ff);
      b_fns_in    = fns_full[23:0];

      c_valid_in  = b_valid_ff;
      c_dq_in     = hsv2rgb_pkg::DEN_FULL - b_fs_ff;
      c_dt_in     = hsv2rgb_pkg::DEN_FULL - b_fns_ff;

      d_valid_in  = c_valid_ff;
      q_prod      = 32'(c_bri_ff) * 32'(c_dq_ff);
      t_prod      = 32'(c_bri_ff) * 32'(c_dt_ff);
      d_qnum_in   = q_prod[31:16];
      d_tnum_in   = t_prod[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sector_ff <= a_sector_in;
      a_frac_ff   <= a_frac_in;
      a_sat_ff    <= a_sat_in;
      a_bri_ff    <= a_bri_in;
      a_pnum_ff   <= a_pnum_in;

      b_sector_ff <= a_sector_ff;
      b_bri_ff    <= a_bri_ff;
      b_pnum_ff   <= a_pnum_ff;
      b_fs_ff     <= b_fs_in;
      b_fns_ff    <= b_fns_in;

      c_sector_ff <= b_sector_ff;
      c_bri_ff    <= b_bri_ff;
      c_pnum_ff   <= b_pnum_ff;
      c_dq_ff     <= c_dq_in;
      c_dt_ff     <= c_dt_in;

      d_sector_ff <= c_sector_ff;
      d_bri_ff    <= c_bri_ff;
      d_pnum_ff   <= c_pnum_ff;
      d_qnum_ff   <= d_qnum_in;
      d_tnum_ff   <= d_tnum_in;
   end

   always_comb begin
      out_term.valid  = d_valid_ff;
      out_term.sector = d_sector_ff;
      out_term.bri    = d_bri_ff;
      out_term.p_num  = d_pnum_ff;
      out_term.q_num  = d_qnum_ff;
      out_term.t_num  = d_tnum_ff;
   end

endmodule

/* rtl/core/hsv2rgb_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB divide and sector select
// Two register stages: divide p, q and t by 255, then route by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
   input  logic                         clock,
   input  logic                         reset,
   input  hsv2rgb_pkg::term_stage_type  in_term,
   output logic                         out_valid,
   output hsv2rgb_pkg::rsp_payload_type out_data
);

   // exact floor(y / 255) for y below 65280
   function automatic logic [7:0] div255(input logic [15:0] y);
      logic [15:0] sum;
      sum    = y + {8'd0, y[15:8]} + 16'd1;
      div255 = sum[15:8];
   endfunction

   logic        e_valid_ff, e_valid_in;
   logic [2:0]  e_sector_ff;
   logic [7:0]  e_bri_ff;
   logic [7:0]  e_p_ff, e_p_in;
   logic [7:0]  e_q_ff, e_q_in;
   logic [7:0]  e_t_ff, e_t_in;

   logic                         f_valid_ff, f_valid_in;
   hsv2rgb_pkg::rsp_payload_type f_data_ff, f_data_in;

   always_comb begin
      e_valid_in = in_term.valid;
      e_p_in     = div255(in_term.p_num);
      e_q_in     = div255(in_term.q_num);
      e_t_in     = div255(in_term.t_num);
   end

   always_comb begin
      f_valid_in = e_valid_ff;
      case (e_sector_ff)
         hsv2rgb_pkg::SECTOR_RED: begin
            f_data_in = '{red: e_bri_ff, green: e_t_ff, blue: e_p_ff};
         end
         hsv2rgb_pkg::SECTOR_YELLOW: begin
            f_data_in = '{red: e_q_ff, green: e_bri_ff, blue: e_p_ff};
         end
         hsv2rgb_pkg::SECTOR_GREEN: begin
            f_data_in = '{red: e_p_ff, green: e_bri_ff, blue: e_t_ff};
         end
         hsv2rgb_pkg::SECTOR_CYAN: begin
            f_data_in = '{red: e_p_ff, green: e_q_ff, blue: e_bri_ff};
         end
         hsv2rgb_pkg::SECTOR_BLUE: begin
            f_data_in = '{red: e_t_ff, green: e_p_ff, blue: e_bri_ff};
         end
         default: begin
            f_data_in = '{red: e_bri_ff, green: e_p_ff, blue: e_q_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_sector_ff <= in_term.sector;
      e_bri_ff    <= in_term.bri;
      e_p_ff      <= e_p_in;
      e_q_ff      <= e_q_in;
      e_t_ff      <= e_t_in;
      f_data_ff   <= f_data_in;
   end

   assign out_valid = f_valid_ff;
   assign out_data  = f_data_ff;

endmodule

/* test/hsv_rgb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches the pixel and color channels, predicts each color from the accepted
// pixel in fixed point, and compares it channel by channel with the block.
// ----------------------------------------------------------------------------
module hsv_rgb_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  hsv2rgb_pkg::req_payload_type req_data,
   input  logic                         rsp_valid,
   input  hsv2rgb_pkg::rsp_payload_type rsp_data,
   output int                           error_count,
   output int                           colors_pending,
   output int                           colors_checked,
   output int                           gray_items
);
   import hsv2rgb_pkg::*;

   rsp_payload_type expected_colors[$];

   function automatic rsp_payload_type convert_hsv(input req_payload_type px);
      logic [63:0]     x, f, s, v, p, q, t, den;
      logic [2:0]      sector;
      rsp_payload_type c;
      s   = {56'd0, px.saturation};
      v   = {56'd0, px.brightness};
      den = {40'd0, DEN_FULL};
      if (s == 64'd0) begin
         c = {px.brightness, px.brightness, px.brightness};
      end else begin
         x      = {48'd0, px.hue} * 64'd6;
         sector = x[18:16];
         f      = {48'd0, x[15:0]};
         p = v * ({56'd0, FULL_SCALE} - s) / {56'd0, FULL_SCALE};
         q = v * (den - f * s) / den;
         t = v * (den - ({47'd0, FRAC_ONE} - f) * s) / den;
         case (sector)
            SECTOR_RED:    c = {v[7:0], t[7:0], p[7:0]};
            SECTOR_YELLOW: c = {q[7:0], v[7:0], p[7:0]};
            SECTOR_GREEN:  c = {p[7:0], v[7:0], t[7:0]};
            SECTOR_CYAN:   c = {p[7:0], q[7:0], v[7:0]};
            SECTOR_BLUE:   c = {t[7:0], p[7:0], v[7:0]};
            default:       c = {v[7:0], p[7:0], q[7:0]};
         endcase
      end
      return c;
   endfunction

   task automatic check_channel(input string chan, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
      end
   endtask

   initial begin
      error_count    = 0;
      colors_pending = 0;
      colors_checked = 0;
      gray_items     = 0;
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         expected_colors.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_colors.size() == 0) begin
               error_count++;
               $display("%0t: unexpected color, expected none, actual %h", $time, rsp_data);
            end else begin
               want = expected_colors.pop_front();
               colors_checked++;
               check_channel("red", want.red, rsp_data.red);
               check_channel("green", want.green, rsp_data.green);
               check_channel("blue", want.blue, rsp_data.blue);
            end
         end
         if (start && !busy) begin
            expected_colors.push_back(convert_hsv(req_data));
            if (req_data.saturation == 8'd0) gray_items++;
         end
      end
      colors_pending = expected_colors.size();
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner pixels and then random pixels under three pacing
// phases, pausing for the pipeline to drain between phases; the checker
// predicts every color and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import hsv2rgb_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 460;

   logic            clock;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   int error_count, colors_pending, colors_checked, gray_items;
   int idle_pct = 0;
   int stall_cycles = 0;

   hsv_to_rgb_converter uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   hsv_rgb_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .error_count(error_count), .colors_pending(colors_pending),
      .colors_checked(colors_checked), .gray_items(gray_items)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_payload_type make_pixel(input int h, input int s, input int v);
      req_payload_type px;
      px.hue        = h[15:0];
      px.saturation = s[7:0];
      px.brightness = v[7:0];
      return px;
   endfunction

   function automatic req_payload_type random_pixel();
      req_payload_type px;
      int              mode;
      int              edge_hue;
      px   = make_pixel($urandom, $urandom, $urandom);
      mode = $urandom_range(9);
      case (mode)
         0: px.saturation = 8'd0;
         1: px.saturation = 8'd255;
         2: px.brightness = $urandom_range(1) ? 8'd255 : 8'd0;
         3: begin
            edge_hue = ($urandom_range(1, 5) * 65536) / 6 + $urandom_range(2) - 1;
            px.hue   = edge_hue[15:0];
         end
         default: ;
      endcase
      return px;
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_pixel(input req_payload_type px);
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_data <= make_pixel($urandom, $urandom, $urandom);
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (colors_pending != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int pct);
      idle_pct = pct;
      repeat (PHASE_ITEMS) send_pixel(random_pixel());
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_pixel(make_pixel(0, 255, 255));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(65535, 255, 255));
      send_pixel(make_pixel(65535, 255, 1));
      send_pixel(make_pixel(0, 0, 255));
      send_pixel(make_pixel(12345, 0, 77));
      send_pixel(make_pixel(10922, 255, 255));
      send_pixel(make_pixel(10923, 255, 255));
      send_pixel(make_pixel(21845, 200, 180));
      send_pixel(make_pixel(21846, 200, 180));
      send_pixel(make_pixel(32768, 255, 255));
      send_pixel(make_pixel(43690, 128, 255));
      send_pixel(make_pixel(43691, 128, 255));
      send_pixel(make_pixel(54613, 1, 255));
      send_pixel(make_pixel(54614, 1, 255));
      send_pixel(make_pixel(5461, 255, 0));
      send_pixel(make_pixel(27306, 170, 85));
      send_pixel(make_pixel(49151, 85, 170));
      send_pixel(make_pixel(60000, 254, 254));
      send_pixel(make_pixel(16384, 255, 255));
      send_pixel(make_pixel(38000, 1, 1));
      wait_idle();

      run_phase(38);
      run_phase(85);
      run_phase(0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d pixels (%0d gray) from corner cases and three pacing phases",
               colors_checked, gray_items);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
